>>> rtl/b91_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b91_pkg
// Shared types and constants of the base91 telemetry frame encoder.
// ----------------------------------------------------------------------------
package b91_pkg;

    localparam int NUM_IN    = 5;
    localparam int TEMP_W    = 12;
    localparam int SCALED_W  = 14;
    localparam int DIGIT_W   = 7;
    localparam int SEQ_W     = 13;
    localparam int CNT_W     = 3;

    localparam int IN_TDATA_W  = ((NUM_IN * TEMP_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DIGIT_W + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [TEMP_W:0]   TEMP_OFFSET = 13'sd880;
    localparam logic signed [TEMP_W-1:0] TEMP_HIGH   = 12'sd2000;
    localparam logic [4:0]               SCALE_MUL   = 5'd23;
    localparam int                       SCALE_SHIFT = 3;
    localparam logic [SCALED_W-1:0]      SCALE_MAX   = 14'd8280;

    localparam logic [SCALED_W-1:0] RADIX       = 14'd91;
    localparam logic [SCALED_W-1:0] RECIP       = 14'd11523;
    localparam int                  RECIP_SHIFT = 20;

    localparam logic [DIGIT_W-1:0] DIGIT_BASE = 7'd33;
    localparam logic [DIGIT_W-1:0] DELIM      = 7'd124;

    typedef struct packed {
        logic [DIGIT_W-1:0] hi;
        logic [DIGIT_W-1:0] lo;
    } t_pair;

endpackage

>>> rtl/b91_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b91_queue
// Small register queue between the frame front end and the byte serialiser.
// ----------------------------------------------------------------------------
module b91_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    n_wr;
    logic [AW-1:0]    n_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> rtl/b91_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b91_front
// Accepts frames, scales the samples and splits every value into base91 digits.
// ----------------------------------------------------------------------------
module b91_front #(
    parameter int MAX_CHANNELS = 5
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_cfg_we,
    input  logic [b91_pkg::CNT_W-1:0]                      i_cfg_wdata,
    input  logic                                           i_valid,
    output logic                                           o_ready,
    input  logic [b91_pkg::NUM_IN*b91_pkg::TEMP_W-1:0]     i_temps,
    input  logic [b91_pkg::NUM_IN-1:0]                     i_sample_ok,
    output logic                                           o_push,
    input  logic                                           i_full,
    output b91_pkg::t_pair [MAX_CHANNELS:0]                o_pairs,
    output logic [b91_pkg::CNT_W-1:0]                      o_count
);
    import b91_pkg::*;

    localparam int LANES = MAX_CHANNELS + 1;

    logic [CNT_W-1:0]    r_cfg_count;
    logic [SEQ_W-1:0]    r_seq;

    logic                r_a_valid;
    logic [CNT_W-1:0]    r_a_count;
    logic [SCALED_W-1:0] r_a_val [LANES];

    logic                r_b_valid;
    logic [CNT_W-1:0]    r_b_count;
    logic [SCALED_W-1:0] r_b_val [LANES];
    logic [DIGIT_W-1:0]  r_b_q   [LANES];

    logic                en_a;
    logic                en_b;
    logic                accept;
    logic [CNT_W-1:0]    n_count;
    logic [SCALED_W-1:0] n_a_val [LANES];
    logic [DIGIT_W-1:0]  n_b_q   [LANES];

    function automatic logic [SCALED_W-1:0] scale_temp(input logic signed [TEMP_W-1:0] t);
        logic signed [TEMP_W:0]  off;
        logic [SCALED_W+2:0]     prod;
        off  = {t[TEMP_W-1], t} + TEMP_OFFSET;
        prod = (SCALED_W+3)'(off[TEMP_W-1:0]) * (SCALED_W+3)'(SCALE_MUL);
        if (off <= 13'sd0) begin
            return '0;
        end else if (t >= TEMP_HIGH) begin
            return SCALE_MAX;
        end
        return prod[SCALED_W+SCALE_SHIFT-1:SCALE_SHIFT];
    endfunction

    assign en_b    = !r_b_valid || !i_full;
    assign en_a    = !r_a_valid || en_b;
    assign o_ready = en_a;
    assign accept  = i_valid && en_a;
    assign o_push  = r_b_valid && !i_full;
    assign o_count = r_b_count;

    assign n_count = (r_cfg_count > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS) : r_cfg_count;

    always_comb begin
        n_a_val[0] = SCALED_W'(r_seq);
        for (int k = 1; k < LANES; k++) begin
            n_a_val[k] = i_sample_ok[k-1]
                       ? scale_temp(i_temps[(k-1)*TEMP_W +: TEMP_W]) : '0;
        end
    end

    // reciprocal multiply, exact for values up to the scale maximum
    always_comb begin
        logic [2*SCALED_W-1:0] prod;
        for (int k = 0; k < LANES; k++) begin
            prod     = (2*SCALED_W)'(r_a_val[k]) * (2*SCALED_W)'(RECIP);
            n_b_q[k] = prod[RECIP_SHIFT+DIGIT_W-1:RECIP_SHIFT];
        end
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            o_pairs[k].hi = r_b_q[k];
            o_pairs[k].lo = DIGIT_W'(r_b_val[k] - SCALED_W'(r_b_q[k]) * RADIX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= '0;
            r_seq       <= '0;
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_count <= i_cfg_wdata;
            end
            if (accept) begin
                r_seq <= r_seq + SEQ_W'(1);
            end
            if (en_a) begin
                r_a_valid <= i_valid;
            end
            if (en_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_count <= n_count;
            r_a_val   <= n_a_val;
        end
        if (en_b && r_a_valid) begin
            r_b_count <= r_a_count;
            r_b_val   <= r_a_val;
            r_b_q     <= n_b_q;
        end
    end

endmodule

>>> rtl/b91_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b91_back
// Serialises a queued frame to delimiter and digit bytes, one per ready cycle.
// ----------------------------------------------------------------------------
module b91_back #(
    parameter int MAX_CHANNELS = 5
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_empty,
    output logic                                   o_pop,
    input  b91_pkg::t_pair [MAX_CHANNELS:0]        i_pairs,
    input  logic [b91_pkg::CNT_W-1:0]              i_count,
    output logic                                   o_tvalid,
    input  logic                                   i_tready,
    output logic [b91_pkg::OUT_TDATA_W-1:0]        o_tdata,
    output logic                                   o_tlast
);
    import b91_pkg::*;

    localparam int LANES = MAX_CHANNELS + 1;
    localparam int CW    = $clog2(2 * MAX_CHANNELS + 4);
    localparam int PW    = $clog2(LANES);

    logic                    r_cur_valid;
    logic [CW-1:0]           r_idx;
    t_pair [MAX_CHANNELS:0]  r_pairs;
    logic [CNT_W-1:0]        r_count;
    logic                    r_o_valid;
    logic [DIGIT_W-1:0]      r_o_byte;
    logic                    r_o_last;

    logic                    emit;
    logic                    is_last;
    logic [CW-1:0]           last_idx;
    logic [CW-1:0]           idx_m1;
    logic [PW-1:0]           pidx;
    t_pair                   sel;
    logic [DIGIT_W-1:0]      n_byte;

    assign emit     = r_cur_valid && (!r_o_valid || i_tready);
    assign last_idx = CW'({r_count, 1'b0}) + CW'(3);
    assign is_last  = (r_idx == last_idx);
    assign o_pop    = !i_empty && (!r_cur_valid || (emit && is_last));
    assign idx_m1   = r_idx - CW'(1);
    assign pidx     = PW'(idx_m1 >> 1);

    always_comb begin
        sel = '0;
        for (int k = 0; k < LANES; k++) begin
            if (pidx == PW'(k)) begin
                sel = r_pairs[k];
            end
        end
    end

    always_comb begin
        if (r_idx == '0 || is_last) begin
            n_byte = DELIM;
        end else begin
            n_byte = (idx_m1[0] ? sel.lo : sel.hi) + DIGIT_BASE;
        end
    end

    assign o_tvalid = r_o_valid;
    assign o_tdata  = OUT_TDATA_W'(r_o_byte);
    assign o_tlast  = r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_idx       <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cur_valid <= 1'b1;
                r_idx       <= '0;
            end else if (emit) begin
                if (is_last) begin
                    r_cur_valid <= 1'b0;
                end else begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (i_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pairs <= i_pairs;
            r_count <= i_count;
        end
        if (emit) begin
            r_o_byte <= n_byte;
            r_o_last <= is_last;
        end
    end

endmodule

>>> rtl/base91_telemetry_frame_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base91_telemetry_frame_encoder
// Encodes telemetry frames of temperature samples into base91 text bytes.
// ----------------------------------------------------------------------------
//  channel   dir  contents
//  s_axis    in   one frame request: five samples in tdata, sample valid bits in tuser
//  m_axis    out  one frame byte in tdata, tlast on the closing delimiter
//  cfg       in   channel count register, i_cfg_we / i_cfg_wdata
//
//  a frame leaves as 4 + 2 * channel_count bytes, one byte per cycle from the
//  serialiser output register while m_axis_tready is high; the front end scales
//  and digit-splits in two stages and hands frames over a two-entry queue to the
//  serialiser frame register, so it takes frames while the serialiser is busy until
//  the queue fills; reset clears the sequence number, channel count and all valid flags
// ----------------------------------------------------------------------------
module base91_telemetry_frame_encoder #(
    parameter int MAX_CHANNELS = 5
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [b91_pkg::CNT_W-1:0]          i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // temp_ch0 [11:0], temp_ch1 [23:12], temp_ch2 [35:24], temp_ch3 [47:36],
    // temp_ch4 [59:48], zero padding above
    input  logic [b91_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // valid_ch0 [0], valid_ch1 [1], valid_ch2 [2], valid_ch3 [3], valid_ch4 [4]
    input  logic [b91_pkg::NUM_IN-1:0]         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_byte [6:0], zero padding above
    output logic [b91_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast
);
    import b91_pkg::*;

    localparam int ENTRY_W = $bits(t_pair) * (MAX_CHANNELS + 1) + CNT_W;

    t_pair [MAX_CHANNELS:0] f_pairs;
    t_pair [MAX_CHANNELS:0] q_pairs;
    logic [CNT_W-1:0]       f_count;
    logic [CNT_W-1:0]       q_count;
    logic                   push;
    logic                   pop;
    logic                   full;
    logic                   empty;
    logic [ENTRY_W-1:0]     q_in;
    logic [ENTRY_W-1:0]     q_out;

    assign q_in               = {f_count, f_pairs};
    assign {q_count, q_pairs} = q_out;

    b91_front #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_temps      (s_axis_tdata[NUM_IN*TEMP_W-1:0]),
        .i_sample_ok  (s_axis_tuser),
        .o_push       (push),
        .i_full       (full),
        .o_pairs      (f_pairs),
        .o_count      (f_count)
    );

    b91_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_full  (full),
        .o_empty (empty)
    );

    b91_back #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .o_pop    (pop),
        .i_pairs  (q_pairs),
        .i_count  (q_count),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

    a_last_is_delim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[DIGIT_W-1:0] == DELIM)
        else $error("closing byte is not a delimiter");

    a_byte_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[DIGIT_W-1:0] >= DIGIT_BASE
                       && m_axis_tdata[DIGIT_W-1:0] <= DELIM)
        else $error("frame byte outside the character range");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("queue written while full");

endmodule
